// File: rtl/atv_pkg.sv
// Shared types, constants and the arctangent table of the tilt detector.
package atv_pkg;

    // Default angle format and CORDIC depth.
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 16;

    // Fraction bits of the arctangent table, square root steps and guard shift.
    localparam int TAB_FRAC   = 20;
    localparam int SQRT_STEPS = 28;
    localparam int MAG_GUARD  = 12;
    localparam int DP_W       = 32;

    // Register map, by word index.
    localparam logic [1:0] REG_PITCH_LOW  = 2'd0;
    localparam logic [1:0] REG_PITCH_HIGH = 2'd1;
    localparam logic [1:0] REG_ROLL_LOW   = 2'd2;
    localparam logic [1:0] REG_ROLL_HIGH  = 2'd3;

    // Register reset values in whole degrees.
    localparam logic [7:0] PITCH_LOW_RST  = 8'd50;
    localparam logic [7:0] PITCH_HIGH_RST = 8'd100;
    localparam logic [7:0] ROLL_LOW_RST   = 8'd80;
    localparam logic [7:0] ROLL_HIGH_RST  = 8'd120;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic               is_vertical;
        logic               tilt_alarm;
    } out_t;

    // atan(2^-i) in degrees scaled by 2^20, rounded.
    function automatic logic signed [DP_W-1:0] atan_tab(input int i);
        logic signed [DP_W-1:0] v;
        case (i)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            20: v = 32'sd57;
            21: v = 32'sd29;
            22: v = 32'sd14;
            23: v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/atv_angle.sv
// Pipelined atan2(n, sqrt(a^2+b^2)) in degrees: squares, square root, CORDIC, rounding.
module atv_angle #(
    parameter int ANGLE_FRAC_BITS = atv_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = atv_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [16:0]                n_in,
    input  logic signed [15:0]                a_in,
    input  logic signed [15:0]                b_in,
    output logic signed [ANGLE_FRAC_BITS+7:0] res_out
);

    localparam int W     = atv_pkg::DP_W;
    localparam int RS    = atv_pkg::SQRT_STEPS;
    localparam int RES_W = ANGLE_FRAC_BITS + 8;
    localparam int SH    = atv_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [W-1:0] HALF = W'(1) <<< (SH - 1);
    localparam logic signed [W-1:0] LIM  = W'(90) <<< ANGLE_FRAC_BITS;

    // Operand capture.
    logic signed [16:0] n_a_reg;
    logic signed [15:0] a_a_reg, b_a_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            n_a_reg <= n_in;
            a_a_reg <= a_in;
            b_a_reg <= b_in;
        end
    end

    // Squares, formed at the full datapath width so they do not wrap.
    logic signed [16:0] n_b_reg;
    logic [W-1:0] asq_reg, bsq_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            n_b_reg <= n_a_reg;
            asq_reg <= W'(W'(a_a_reg) * W'(a_a_reg));
            bsq_reg <= W'(W'(b_a_reg) * W'(b_a_reg));
        end
    end

    // Sum of squares.
    logic signed [16:0] n_c_reg;
    logic [W-1:0] sq_c_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            n_c_reg  <= n_b_reg;
            sq_c_reg <= asq_reg + bsq_reg;
        end
    end

    // Square root of sq * 2^24, one result bit per stage.
    logic [W-1:0]       sq_p   [0:RS];
    logic [W-1:0]       rem_p  [0:RS];
    logic [RS-1:0]      root_p [0:RS];
    logic signed [16:0] n_p    [0:RS];

    assign sq_p[0]   = sq_c_reg;
    assign rem_p[0]  = '0;
    assign root_p[0] = '0;
    assign n_p[0]    = n_c_reg;

    for (genvar k = 0; k < RS; k++) begin : g_sqrt
        localparam int P = RS - 1 - k;
        logic [1:0]   pair;
        logic [W-1:0] rem_sh, trial;
        if (P >= 12) begin : g_pair
            assign pair = sq_p[k][2*P-23 -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end
        assign rem_sh = {rem_p[k][W-3:0], pair};
        assign trial  = {2'b00, root_p[k], 2'b01};

        logic [W-1:0]       sq_reg, rem_reg;
        logic [RS-1:0]      root_reg;
        logic signed [16:0] n_reg;
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg <= sq_p[k];
                n_reg  <= n_p[k];
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_p[k][RS-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_p[k][RS-2:0], 1'b0};
                end
            end
        end
        assign sq_p[k+1]   = sq_reg;
        assign rem_p[k+1]  = rem_reg;
        assign root_p[k+1] = root_reg;
        assign n_p[k+1]    = n_reg;
    end

    // CORDIC vectoring, one micro-rotation per stage.
    logic signed [W-1:0] x_c [0:CORDIC_STAGES];
    logic signed [W-1:0] y_c [0:CORDIC_STAGES];
    logic signed [W-1:0] z_c [0:CORDIC_STAGES];
    logic                nz_c [0:CORDIC_STAGES];

    assign x_c[0]  = W'(root_p[RS]);
    assign y_c[0]  = W'(n_p[RS]) <<< atv_pkg::MAG_GUARD;
    assign z_c[0]  = '0;
    assign nz_c[0] = (n_p[RS] != 17'sd0);

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [W-1:0] xs, ys;
        logic signed [W-1:0] x_reg, y_reg, z_reg;
        logic                nz_reg;
        assign xs = x_c[i] >>> i;
        assign ys = y_c[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                nz_reg <= nz_c[i];
                if (!y_c[i][W-1]) begin
                    x_reg <= x_c[i] + ys;
                    y_reg <= y_c[i] - xs;
                    z_reg <= z_c[i] + atv_pkg::atan_tab(i);
                end else begin
                    x_reg <= x_c[i] - ys;
                    y_reg <= y_c[i] + xs;
                    z_reg <= z_c[i] - atv_pkg::atan_tab(i);
                end
            end
        end
        assign x_c[i+1]  = x_reg;
        assign y_c[i+1]  = y_reg;
        assign z_c[i+1]  = z_reg;
        assign nz_c[i+1] = nz_reg;
    end

    // Round to the output fraction, saturate to +-90 degrees.
    logic signed [W-1:0] z_rnd, z_sat;
    always_comb begin
        z_rnd = (z_c[CORDIC_STAGES] + HALF) >>> SH;
        if (z_rnd > LIM) begin
            z_sat = LIM;
        end else if (z_rnd < -LIM) begin
            z_sat = -LIM;
        end else begin
            z_sat = z_rnd;
        end
    end

    logic signed [RES_W-1:0] res_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= nz_c[CORDIC_STAGES] ? RES_W'(z_sat) : '0;
        end
    end
    assign res_out = res_reg;

endmodule

// File: rtl/accel_tilt_vertical_detector.sv
// Top level of the accelerometer tilt detector with its register port and output stage.
//
// One request on the s_ channel carries an x, y, z accelerometer sample; one
// request on the m_ channel returns pitch and roll in degrees with
// ANGLE_FRAC_BITS fraction bits, the vertical flag and its inverse, the alarm.
// A sample is vertical when |pitch| or |roll| lies strictly inside its window.
// The four window bounds must be written over the APB port at byte addresses
// 0, 4, 8 and 12 only while the block is idle; the block itself does not
// enforce this, so the user is bound by it. Throughput is one sample per cycle
// while m_ready does not stall the output. An accepted sample passes capture,
// squaring, summing, the 28 square root steps and the CORDIC stages, one per
// register stage, then rounding, the window compare and the output register.
// The whole pipeline advances together; when m_ready is low with a result
// waiting, every stage holds and s_ready drops, so nothing is lost or repeated.
// Reset clears the valid bits and returns the window bounds to 50/100 degrees
// for pitch and 80/120 degrees for roll.
module accel_tilt_vertical_detector #(
    parameter int ANGLE_FRAC_BITS = atv_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = atv_pkg::CORDIC_STAGES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  atv_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output atv_pkg::out_t m_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int RES_W   = ANGLE_FRAC_BITS + 8;
    localparam int ANG_LAT = atv_pkg::SQRT_STEPS + 4 + CORDIC_STAGES;

    // Window registers.
    logic [7:0] p_lo_reg, p_hi_reg, r_lo_reg, r_hi_reg;
    logic       wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_lo_reg <= atv_pkg::PITCH_LOW_RST;
            p_hi_reg <= atv_pkg::PITCH_HIGH_RST;
            r_lo_reg <= atv_pkg::ROLL_LOW_RST;
            r_hi_reg <= atv_pkg::ROLL_HIGH_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                atv_pkg::REG_PITCH_LOW:  p_lo_reg <= pwdata[7:0];
                atv_pkg::REG_PITCH_HIGH: p_hi_reg <= pwdata[7:0];
                atv_pkg::REG_ROLL_LOW:   r_lo_reg <= pwdata[7:0];
                atv_pkg::REG_ROLL_HIGH:  r_hi_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[3:2])
            atv_pkg::REG_PITCH_LOW:  prdata = {24'd0, p_lo_reg};
            atv_pkg::REG_PITCH_HIGH: prdata = {24'd0, p_hi_reg};
            atv_pkg::REG_ROLL_LOW:   prdata = {24'd0, r_lo_reg};
            atv_pkg::REG_ROLL_HIGH:  prdata = {24'd0, r_hi_reg};
            default:                 prdata = '0;
        endcase
    end

    // Global advance: the pipeline moves unless a result waits on a stalled sink.
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    // Valid bits travel alongside the angle pipelines.
    logic [ANG_LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[ANG_LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[ANG_LAT-1];
        end
    end

    // Pitch uses y over the x-z magnitude, roll uses -x over the y-z magnitude.
    logic signed [16:0]      neg_x;
    logic signed [RES_W-1:0] pitch_res, roll_res;
    assign neg_x = -{s_data.accel_x[15], s_data.accel_x};

    atv_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_pitch (
        .aclk    (aclk),
        .en      (en),
        .n_in    ({s_data.accel_y[15], s_data.accel_y}),
        .a_in    (s_data.accel_x),
        .b_in    (s_data.accel_z),
        .res_out (pitch_res)
    );

    atv_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_roll (
        .aclk    (aclk),
        .en      (en),
        .n_in    (neg_x),
        .a_in    (s_data.accel_y),
        .b_in    (s_data.accel_z),
        .res_out (roll_res)
    );

    // Window test on the magnitudes; bounds are exclusive.
    logic [RES_W-1:0] p_mag, r_mag;
    logic             vert;
    assign p_mag = pitch_res[RES_W-1] ? RES_W'(-pitch_res) : RES_W'(pitch_res);
    assign r_mag = roll_res[RES_W-1] ? RES_W'(-roll_res) : RES_W'(roll_res);
    assign vert  = (p_mag > {p_lo_reg, ANGLE_FRAC_BITS'(0)} &&
                    p_mag < {p_hi_reg, ANGLE_FRAC_BITS'(0)}) ||
                   (r_mag > {r_lo_reg, ANGLE_FRAC_BITS'(0)} &&
                    r_mag < {r_hi_reg, ANGLE_FRAC_BITS'(0)});

    // Output register.
    atv_pkg::out_t out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.pitch_angle <= 16'(pitch_res);
            out_reg.roll_angle  <= 16'(roll_res);
            out_reg.is_vertical <= vert;
            out_reg.tilt_alarm  <= !vert;
        end
    end
    assign m_data = out_reg;

endmodule
